@@ rtl/clnbs_pkg.sv @@
// shared types, codes and helpers for the character lcd nibble bus sequencer
`default_nettype none

package clnbs_pkg;

	// results one request can cause
	localparam int MaxResults = 4;
	localparam int IdxW       = $clog2(MaxResults);

	// request codes
	localparam logic [2:0] CMD_COMMAND = 3'd0;
	localparam logic [2:0] CMD_DATA    = 3'd1;
	localparam logic [2:0] CMD_CURSOR  = 3'd2;
	localparam logic [2:0] CMD_BUSY    = 3'd3;
	localparam logic [2:0] CMD_INIT    = 3'd4;

	// bus operation codes
	localparam logic [1:0] OP_STATUS  = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_REFUSED = 2'd2;

	// register indexes
	localparam logic [1:0] REG_EDGE    = 2'd0;
	localparam logic [1:0] REG_POWERUP = 2'd1;
	localparam logic [1:0] REG_GAP     = 2'd2;

	// register reset values
	localparam logic [9:0]  EDGE_RESET    = 10'd20;
	localparam logic [15:0] POWERUP_RESET = 16'd20000;
	localparam logic [9:0]  GAP_RESET     = 10'd50;

	// panel constants
	localparam logic [7:0] ADDR_FLAG    = 8'h80;
	localparam int         BusyBit      = 3;
	localparam logic [4:0] COL_MAX      = 5'd19;
	localparam logic [6:0] ROW1_OFFSET  = 7'd20;
	localparam logic [6:0] ROW2_OFFSET  = 7'd64;
	localparam logic [6:0] ROW3_OFFSET  = 7'd84;
	localparam logic [3:0] INIT_NIBBLE  = 4'h3;
	localparam logic [3:0] FINAL_NIBBLE = 4'h2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] byte_value;
		logic [7:0] col;
		logic [7:0] row;
		logic [3:0] busy_nibble;
	} req_t;

	typedef struct packed {
		logic [1:0]  bus_op;
		logic        reg_select;
		logic [3:0]  nibble;
		logic [15:0] wait_us;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [9:0]  edge_delay_us;
		logic [15:0] powerup_delay_us;
		logic [9:0]  init_gap_us;
	} cfg_t;

	// results of one request, in order, up to last_idx
	typedef struct packed {
		rsp_t [MaxResults-1:0] res;
		logic [IdxW-1:0]       last_idx;
	} burst_t;

	function automatic rsp_t make_rsp(logic [1:0] op, logic rs, logic [3:0] nib,
		logic [15:0] wait_us, logic last);
		rsp_t r;
		r.bus_op     = op;
		r.reg_select = rs;
		r.nibble     = nib;
		r.wait_us    = wait_us;
		r.last       = last;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/clnbs_regs.sv @@
// apb configuration registers of the sequencer
`default_nettype none

module clnbs_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output clnbs_pkg::cfg_t        cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.edge_delay_us    <= clnbs_pkg::EDGE_RESET;
			cfg.powerup_delay_us <= clnbs_pkg::POWERUP_RESET;
			cfg.init_gap_us      <= clnbs_pkg::GAP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				clnbs_pkg::REG_EDGE:    cfg.edge_delay_us    <= pwdata[9:0];
				clnbs_pkg::REG_POWERUP: cfg.powerup_delay_us <= pwdata[15:0];
				clnbs_pkg::REG_GAP:     cfg.init_gap_us      <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		case (reg_idx)
			clnbs_pkg::REG_EDGE:    prdata = {22'd0, cfg.edge_delay_us};
			clnbs_pkg::REG_POWERUP: prdata = {16'd0, cfg.powerup_delay_us};
			clnbs_pkg::REG_GAP:     prdata = {22'd0, cfg.init_gap_us};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/clnbs_decode.sv @@
// request decode, busy-wait state and the registered result burst
`default_nettype none

module clnbs_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire clnbs_pkg::cfg_t   cfg,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire clnbs_pkg::req_t   in_data,
	output logic                   burst_valid,
	output clnbs_pkg::burst_t      burst,
	input  wire logic              burst_take
);

	logic              waiting_q;
	logic [7:0]        pend_byte_q;
	logic              pend_sel_q;
	logic              valid_s1;
	clnbs_pkg::burst_t burst_s1;

	logic              in_fire;
	logic              waiting_d;
	logic [7:0]        pend_byte_d;
	logic              pend_sel_d;
	clnbs_pkg::burst_t burst_d;

	logic [10:0] gap_sum;
	logic [16:0] pwr_sum;
	logic [15:0] edge_wait;
	logic [15:0] gap_wait;
	logic [15:0] pwr_wait;
	logic [4:0]  col_c;
	logic [6:0]  row_off;
	logic [6:0]  pos;
	logic [7:0]  cursor_byte;

	assign in_stall    = valid_s1 && !burst_take;
	assign in_fire     = in_valid && !in_stall;
	assign burst_valid = valid_s1;
	assign burst       = burst_s1;

	// delays, saturated to 16 bits
	always_comb begin
		gap_sum   = {1'b0, cfg.edge_delay_us} + {1'b0, cfg.init_gap_us};
		pwr_sum   = {6'd0, gap_sum} + {1'b0, cfg.powerup_delay_us};
		edge_wait = {6'd0, cfg.edge_delay_us};
		gap_wait  = {5'd0, gap_sum};
		pwr_wait  = pwr_sum[16] ? 16'hFFFF : pwr_sum[15:0];
	end

	// cursor address
	always_comb begin
		col_c = (in_data.col > {3'd0, clnbs_pkg::COL_MAX}) ? 5'd0 : in_data.col[4:0];
		case (in_data.row)
			8'd1:    row_off = clnbs_pkg::ROW1_OFFSET;
			8'd2:    row_off = clnbs_pkg::ROW2_OFFSET;
			8'd3:    row_off = clnbs_pkg::ROW3_OFFSET;
			default: row_off = 7'd0;
		endcase
		pos         = {2'd0, col_c} + row_off;
		cursor_byte = clnbs_pkg::ADDR_FLAG | {1'b0, pos};
	end

	// request decode
	always_comb begin
		waiting_d        = waiting_q;
		pend_byte_d      = pend_byte_q;
		pend_sel_d       = pend_sel_q;
		burst_d.res      = '0;
		burst_d.last_idx = '0;
		if (waiting_q) begin
			if (in_data.cmd != clnbs_pkg::CMD_BUSY) begin
				burst_d.res[0] = clnbs_pkg::make_rsp(clnbs_pkg::OP_REFUSED, 1'b0, 4'd0,
					16'd0, 1'b1);
			end else if (in_data.busy_nibble[clnbs_pkg::BusyBit]) begin
				burst_d.res[0] = clnbs_pkg::make_rsp(clnbs_pkg::OP_STATUS, 1'b0, 4'd0,
					edge_wait, 1'b1);
			end else begin
				burst_d.res[0] = clnbs_pkg::make_rsp(clnbs_pkg::OP_WRITE, pend_sel_q,
					pend_byte_q[7:4], edge_wait, 1'b0);
				burst_d.res[1] = clnbs_pkg::make_rsp(clnbs_pkg::OP_WRITE, pend_sel_q,
					pend_byte_q[3:0], edge_wait, 1'b1);
				burst_d.last_idx = 2'd1;
				waiting_d        = 1'b0;
			end
		end else begin
			case (in_data.cmd)
				clnbs_pkg::CMD_COMMAND, clnbs_pkg::CMD_DATA: begin
					burst_d.res[0] = clnbs_pkg::make_rsp(clnbs_pkg::OP_STATUS, 1'b0, 4'd0,
						edge_wait, 1'b1);
					pend_byte_d = in_data.byte_value;
					pend_sel_d  = (in_data.cmd == clnbs_pkg::CMD_DATA);
					waiting_d   = 1'b1;
				end
				clnbs_pkg::CMD_CURSOR: begin
					burst_d.res[0] = clnbs_pkg::make_rsp(clnbs_pkg::OP_STATUS, 1'b0, 4'd0,
						edge_wait, 1'b1);
					pend_byte_d = cursor_byte;
					pend_sel_d  = 1'b0;
					waiting_d   = 1'b1;
				end
				clnbs_pkg::CMD_INIT: begin
					burst_d.res[0] = clnbs_pkg::make_rsp(clnbs_pkg::OP_WRITE, 1'b0,
						clnbs_pkg::INIT_NIBBLE, pwr_wait, 1'b0);
					burst_d.res[1] = clnbs_pkg::make_rsp(clnbs_pkg::OP_WRITE, 1'b0,
						clnbs_pkg::INIT_NIBBLE, gap_wait, 1'b0);
					burst_d.res[2] = clnbs_pkg::make_rsp(clnbs_pkg::OP_WRITE, 1'b0,
						clnbs_pkg::INIT_NIBBLE, gap_wait, 1'b0);
					burst_d.res[3] = clnbs_pkg::make_rsp(clnbs_pkg::OP_WRITE, 1'b0,
						clnbs_pkg::FINAL_NIBBLE, gap_wait, 1'b1);
					burst_d.last_idx = 2'd3;
				end
				default: begin
					burst_d.res[0] = clnbs_pkg::make_rsp(clnbs_pkg::OP_REFUSED, 1'b0, 4'd0,
						16'd0, 1'b1);
				end
			endcase
		end
	end

	// busy-wait state and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q   <= 1'b0;
			pend_byte_q <= 8'd0;
			pend_sel_q  <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			if (in_fire) begin
				waiting_q   <= waiting_d;
				pend_byte_q <= pend_byte_d;
				pend_sel_q  <= pend_sel_d;
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (burst_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// burst payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			burst_s1 <= burst_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/clnbs_emit.sv @@
// result register that hands out a burst one result per transaction
`default_nettype none

module clnbs_emit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               burst_valid,
	input  wire clnbs_pkg::burst_t  burst,
	output logic                    burst_take,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output clnbs_pkg::rsp_t         out_data
);

	logic                       valid_q;
	logic [clnbs_pkg::IdxW-1:0] idx_q;
	clnbs_pkg::burst_t          burst_q;
	logic                       out_fire;
	logic                       at_end;

	assign out_valid  = valid_q;
	assign out_data   = burst_q.res[idx_q];
	assign out_fire   = valid_q && !out_stall;
	assign at_end     = (idx_q == burst_q.last_idx);
	assign burst_take = burst_valid && (!valid_q || (out_fire && at_end));

	// result index and valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (burst_take) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (out_fire) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// burst held for the output
	always_ff @(posedge clk) begin
		if (burst_take) begin
			burst_q <= burst;
		end
	end

endmodule

`default_nettype wire

@@ rtl/char_lcd_nibble_bus_sequencer_unit.sv @@
// top level of the character lcd nibble bus sequencer
// Turns requests for a 4-bit character panel into bus operations. Each input
// transaction (cmd, byte, cursor, busy response, init) yields one to four
// result transactions; the last one carries last set, and every result
// carries the wait in microseconds to hold after it.
// Channels use valid and stall; a transaction moves when valid is high and
// stall is low. Timing registers are written through the apb port.
// A request is decoded into the burst register, and its burst then moves to
// the result register of the output stage, from which its first result shows.
// Throughput: one result per cycle unless the receiver stalls; a request
// yields one result per bus operation (one, two for a byte write, four for
// init), so single-result requests flow at one per cycle. The burst register
// lets the next request be accepted while the output holds a stalled result.
// When the receiver stalls, the current result holds; input stall rises once
// the burst register is also full.
// Reset clears the busy-wait state, empties both stages and loads the timing
// registers with their defaults.
`default_nettype none

module char_lcd_nibble_bus_sequencer_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire clnbs_pkg::req_t   in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output clnbs_pkg::rsp_t        out_data
);

	clnbs_pkg::cfg_t   cfg;
	clnbs_pkg::burst_t burst;
	logic              burst_valid;
	logic              burst_take;

	// configuration registers
	clnbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// request decode
	clnbs_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.burst_valid (burst_valid),
		.burst       (burst),
		.burst_take  (burst_take)
	);

	// result output
	clnbs_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_valid (burst_valid),
		.burst       (burst),
		.burst_take  (burst_take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

@@ rtl/clnbs_checker.sv @@
// port-level checks of the sequencer and their bind to the top level
`default_nettype none

module clnbs_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              psel,
	input wire logic              penable,
	input wire logic              pwrite,
	input wire logic [3:0]        paddr,
	input wire logic [31:0]       pwdata,
	input wire logic [31:0]       prdata,
	input wire logic              pready,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire clnbs_pkg::req_t   in_data,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire clnbs_pkg::rsp_t   out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// the rest of a burst follows without a gap
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last |=> out_valid)
		else $error("burst broken off before its last result");

	// a refusal is a single bare result
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bus_op == clnbs_pkg::OP_REFUSED |->
		out_data.last && out_data.wait_us == 16'd0 && out_data.nibble == 4'd0 &&
		!out_data.reg_select)
		else $error("malformed refusal");

	// a status read pair ends its request and drives no data
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bus_op == clnbs_pkg::OP_STATUS |->
		out_data.last && out_data.nibble == 4'd0 && !out_data.reg_select)
		else $error("malformed status read");

endmodule

bind char_lcd_nibble_bus_sequencer_unit clnbs_checker u_clnbs_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the character lcd nibble bus sequencer
module tb;

	// register index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// request codes the block does not define
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	localparam int WatchdogLimit = 2000;
	localparam int LongHoldCycles = 300;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            psel = 1'b0;
	logic            penable = 1'b0;
	logic            pwrite = 1'b0;
	logic [3:0]      paddr = '0;
	logic [31:0]     pwdata = '0;
	logic [31:0]     prdata;
	logic            pready;
	logic            in_valid = 1'b0;
	logic            in_stall;
	clnbs_pkg::req_t in_data = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	clnbs_pkg::rsp_t out_data;

	// stimulus and prediction stores
	clnbs_pkg::req_t request_queue[$];
	clnbs_pkg::rsp_t expected_bus_ops[$];
	clnbs_pkg::rsp_t want;

	// predictor copy of the timing registers and busy-wait state
	logic [9:0]  m_edge = clnbs_pkg::EDGE_RESET;
	logic [15:0] m_powerup = clnbs_pkg::POWERUP_RESET;
	logic [9:0]  m_gap = clnbs_pkg::GAP_RESET;
	logic        m_waiting = 1'b0;
	logic [7:0]  m_byte = '0;
	logic        m_sel = 1'b0;

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_settings = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;

	char_lcd_nibble_bus_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] sat16(input int v);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	task automatic note_failure(input string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask

	task automatic push_bus_op(input logic [1:0] op, input logic rs, input logic [3:0] nib,
		input logic [15:0] wait_us, input logic last);
		clnbs_pkg::rsp_t r;
		r.bus_op     = op;
		r.reg_select = rs;
		r.nibble     = nib;
		r.wait_us    = wait_us;
		r.last       = last;
		expected_bus_ops.push_back(r);
	endtask

	// a byte write starts with one status read pair
	task automatic start_byte_write(input logic [7:0] value, input logic sel);
		m_byte    = value;
		m_sel     = sel;
		m_waiting = 1'b1;
		push_bus_op(clnbs_pkg::OP_STATUS, 1'b0, 4'h0, sat16(int'(m_edge)), 1'b1);
	endtask

	// expected bus operations for one accepted request
	task automatic predict_bus_ops(input clnbs_pkg::req_t r);
		logic [15:0] edge_wait;
		logic [15:0] init_wait;
		logic [7:0]  addr;
		edge_wait = sat16(int'(m_edge));
		init_wait = sat16(int'(m_edge) + int'(m_gap));
		if (m_waiting) begin
			if (r.cmd != clnbs_pkg::CMD_BUSY) begin
				push_bus_op(clnbs_pkg::OP_REFUSED, 1'b0, 4'h0, 16'h0, 1'b1);
			end else if (r.busy_nibble[clnbs_pkg::BusyBit]) begin
				push_bus_op(clnbs_pkg::OP_STATUS, 1'b0, 4'h0, edge_wait, 1'b1);
			end else begin
				push_bus_op(clnbs_pkg::OP_WRITE, m_sel, m_byte[7:4], edge_wait, 1'b0);
				push_bus_op(clnbs_pkg::OP_WRITE, m_sel, m_byte[3:0], edge_wait, 1'b1);
				m_waiting = 1'b0;
			end
		end else begin
			case (r.cmd)
				clnbs_pkg::CMD_COMMAND, clnbs_pkg::CMD_DATA: begin
					start_byte_write(r.byte_value, r.cmd == clnbs_pkg::CMD_DATA);
				end
				clnbs_pkg::CMD_CURSOR: begin
					addr = (r.col > 8'(clnbs_pkg::COL_MAX)) ? 8'd0 : r.col;
					case (r.row)
						8'd1: addr = addr + 8'(clnbs_pkg::ROW1_OFFSET);
						8'd2: addr = addr + 8'(clnbs_pkg::ROW2_OFFSET);
						8'd3: addr = addr + 8'(clnbs_pkg::ROW3_OFFSET);
						default: ;
					endcase
					start_byte_write(clnbs_pkg::ADDR_FLAG | addr, 1'b0);
				end
				clnbs_pkg::CMD_INIT: begin
					// the first nibble also carries the power-up hold
					push_bus_op(clnbs_pkg::OP_WRITE, 1'b0, clnbs_pkg::INIT_NIBBLE,
						sat16(int'(init_wait) + int'(m_powerup)), 1'b0);
					push_bus_op(clnbs_pkg::OP_WRITE, 1'b0, clnbs_pkg::INIT_NIBBLE,
						init_wait, 1'b0);
					push_bus_op(clnbs_pkg::OP_WRITE, 1'b0, clnbs_pkg::INIT_NIBBLE,
						init_wait, 1'b0);
					push_bus_op(clnbs_pkg::OP_WRITE, 1'b0, clnbs_pkg::FINAL_NIBBLE,
						init_wait, 1'b1);
				end
				default: begin
					push_bus_op(clnbs_pkg::OP_REFUSED, 1'b0, 4'h0, 16'h0, 1'b1);
				end
			endcase
		end
	endtask

	// driver: presents queued requests, holds a stalled transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_data  <= request_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= LongHoldCycles;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor: check each result transaction, then predict from each request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_bus_ops.size() == 0) begin
					note_failure($sformatf("result %h with nothing expected", out_data));
				end else begin
					want = expected_bus_ops.pop_front();
					if (out_data.bus_op !== want.bus_op)
						note_failure($sformatf("result %0d bus_op got %0d expected %0d",
							n_results, out_data.bus_op, want.bus_op));
					if (out_data.reg_select !== want.reg_select)
						note_failure($sformatf("result %0d reg_select got %0d expected %0d",
							n_results, out_data.reg_select, want.reg_select));
					if (out_data.nibble !== want.nibble)
						note_failure($sformatf("result %0d nibble got %h expected %h",
							n_results, out_data.nibble, want.nibble));
					if (out_data.wait_us !== want.wait_us)
						note_failure($sformatf("result %0d wait_us got %0d expected %0d",
							n_results, out_data.wait_us, want.wait_us));
					if (out_data.last !== want.last)
						note_failure($sformatf("result %0d last got %0d expected %0d",
							n_results, out_data.last, want.last));
				end
			end
			if (in_valid && !in_stall) begin
				n_requests++;
				predict_bus_ops(in_data);
			end
		end
	end

	// watchdog on cycles with work outstanding and no transaction
	always @(posedge clk) begin
		if (arst_n && (request_queue.size() != 0 || in_valid || expected_bus_ops.size() != 0)
			&& !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
			idle_cycles++;
			if (idle_cycles >= WatchdogLimit) begin
				$display("timeout after %0d cycles without progress", idle_cycles);
				$display("Mismatches found");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	// apb write: setup cycle then access cycle
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			clnbs_pkg::REG_EDGE:    m_edge = val[9:0];
			clnbs_pkg::REG_POWERUP: m_powerup = val[15:0];
			clnbs_pkg::REG_GAP:     m_gap = val[9:0];
			default: ;
		endcase
	endtask

	// timing registers, with junk in the unused upper bits
	task automatic set_timing(input logic [9:0] e, input logic [15:0] p, input logic [9:0] g);
		cfg_write(clnbs_pkg::REG_EDGE, ($urandom & 32'hFFFF_FC00) | 32'(e));
		cfg_write(clnbs_pkg::REG_POWERUP, ($urandom & 32'hFFFF_0000) | 32'(p));
		cfg_write(clnbs_pkg::REG_GAP, ($urandom & 32'hFFFF_FC00) | 32'(g));
		n_settings++;
	endtask

	// wait until every queued request has been answered, checked between edges
	task automatic drain;
		while (request_queue.size() != 0 || in_valid || expected_bus_ops.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic clnbs_pkg::req_t rand_req;
		clnbs_pkg::req_t r;
		r.cmd         = 3'($urandom_range(7));
		r.byte_value  = 8'($urandom_range(255));
		r.col         = 8'($urandom_range(255));
		r.row         = 8'($urandom_range(255));
		r.busy_nibble = 4'($urandom_range(15));
		return r;
	endfunction

	function automatic clnbs_pkg::req_t mk_req(input logic [2:0] cmd, input logic [7:0] value,
		input logic [7:0] col, input logic [7:0] row, input logic [3:0] busy);
		clnbs_pkg::req_t r;
		r.cmd         = cmd;
		r.byte_value  = value;
		r.col         = col;
		r.row         = row;
		r.busy_nibble = busy;
		return r;
	endfunction

	// mostly complete request and busy-response sequences, some noise
	task automatic add_random_items(input int n);
		int count;
		int k;
		int j;
		int pick;
		clnbs_pkg::req_t r;
		clnbs_pkg::req_t noise;
		count = 0;
		while (count < n) begin
			r = rand_req();
			if ($urandom_range(99) < 15) begin
				request_queue.push_back(r);
				count++;
			end else begin
				pick = $urandom_range(9);
				if (pick < 3) r.cmd = clnbs_pkg::CMD_COMMAND;
				else if (pick < 6) r.cmd = clnbs_pkg::CMD_DATA;
				else if (pick < 9) r.cmd = clnbs_pkg::CMD_CURSOR;
				else r.cmd = clnbs_pkg::CMD_INIT;
				if (r.cmd == clnbs_pkg::CMD_CURSOR) begin
					if ($urandom_range(1) != 0) r.col = 8'($urandom_range(19));
					if ($urandom_range(3) != 0) r.row = 8'($urandom_range(3));
				end
				request_queue.push_back(r);
				count++;
				if (r.cmd != clnbs_pkg::CMD_INIT) begin
					k = $urandom_range(3);
					for (j = 0; j <= k; j++) begin
						// a stray request in the middle of the busy wait
						if ($urandom_range(9) == 0) begin
							noise = rand_req();
							if (noise.cmd == clnbs_pkg::CMD_BUSY) noise.cmd = clnbs_pkg::CMD_INIT;
							request_queue.push_back(noise);
							count++;
						end
						r = rand_req();
						r.cmd = clnbs_pkg::CMD_BUSY;
						r.busy_nibble[clnbs_pkg::BusyBit] = (j != k);
						request_queue.push_back(r);
						count++;
					end
				end
			end
		end
	endtask

	task automatic run_phase(input int send_idle, input int recv_stall, input int n);
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		add_random_items(n);
		drain();
	endtask

	// test sequence
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part under reset timing
		request_queue.push_back(mk_req(clnbs_pkg::CMD_INIT, 8'h00, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_COMMAND, 8'h00, 8'hFF, 8'hFF, 4'hF));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'hFF, 8'h00, 8'h00, 4'h8));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_DATA, 8'h5A, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_INIT, 8'h00, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_CURSOR, 8'h00, 8'h05, 8'h01, 4'h0));
		request_queue.push_back(mk_req(CMD_RSVD7, 8'h00, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00, 4'h7));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00, 4'hF));
		request_queue.push_back(mk_req(CMD_RSVD5, 8'hFF, 8'hFF, 8'hFF, 4'hF));
		request_queue.push_back(mk_req(CMD_RSVD6, 8'h00, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_DATA, 8'hFF, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00, 4'hF));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_CURSOR, 8'h00, 8'd19, 8'd3, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_CURSOR, 8'h00, 8'd20, 8'd1, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_CURSOR, 8'h00, 8'd255, 8'd255, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_CURSOR, 8'h00, 8'd0, 8'd2, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_COMMAND, 8'hA5, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_COMMAND, 8'h3C, 8'h00, 8'h00, 4'h0));
		request_queue.push_back(mk_req(clnbs_pkg::CMD_BUSY, 8'h00, 8'h00, 8'h00, 4'h3));
		drain();

		// all delays zero, sender idling
		set_timing(10'd0, 16'd0, 10'd0);
		run_phase(56, 0, 60);

		// all delays at maximum, receiver stalling, sender pause midway
		set_timing(10'd1023, 16'd65535, 10'd1023);
		run_phase(0, 56, 30);
		run_phase(0, 56, 30);

		// random timing, light idling on both sides
		set_timing(10'($urandom_range(1023)), 16'($urandom_range(65535)),
			10'($urandom_range(1023)));
		run_phase(7, 7, 60);

		// reset timing again plus a write to the unused index; long receiver hold-off
		cfg_write(REG_UNUSED, $urandom);
		set_timing(clnbs_pkg::EDGE_RESET, clnbs_pkg::POWERUP_RESET, clnbs_pkg::GAP_RESET);
		idle_pct  = 0;
		stall_pct = 0;
		@(posedge clk);
		hold_toggle <= ~hold_toggle;
		add_random_items(50);
		drain();

		// wide edge delay, no power-up hold
		set_timing(10'd1023, 16'd0, 10'd0);
		run_phase(0, 0, 60);

		// random timing, both sides idling
		set_timing(10'($urandom_range(1023)), 16'($urandom_range(65535)),
			10'($urandom_range(1023)));
		run_phase(56, 56, 70);

		repeat (10) @(posedge clk);
		if (expected_bus_ops.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_bus_ops.size()));

		$display("run covered %0d requests and %0d results over %0d timing settings",
			n_requests, n_results, n_settings);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/clnbs_pkg.sv
rtl/clnbs_regs.sv
rtl/clnbs_decode.sv
rtl/clnbs_emit.sv
rtl/char_lcd_nibble_bus_sequencer_unit.sv
rtl/clnbs_checker.sv
tb/tb.sv
